// ----- src/tklc_pkg.sv -----
package tklc_pkg;

	// Fixed field widths of the stream words
	localparam int LIGHT_W = 3;
	localparam int CNT_W   = 16;
	localparam int IN_W    = 8;
	localparam int OUT_W   = 16;

	typedef enum logic [1:0] {
		MODE_SCAN = 2'd0,
		MODE_LED  = 2'd1,
		MODE_SET  = 2'd2
	} mode_t;

	// Configuration register indexes
	localparam logic [1:0] REG_ACTION = 2'd0;
	localparam logic [1:0] REG_RESET  = 2'd1;
	localparam logic [1:0] REG_REBOOT = 2'd2;

	localparam logic [CNT_W-1:0] ACTION_RST = 16'd2;
	localparam logic [CNT_W-1:0] RESET_RST  = 16'd300;
	localparam logic [CNT_W-1:0] REBOOT_RST = 16'd600;

	typedef struct packed {
		logic [CNT_W-1:0] action;
		logic [CNT_W-1:0] reset;
		logic [CNT_W-1:0] reboot;
	} thresh_t;

	typedef struct packed {
		logic [LIGHT_W-1:0] lights;
		logic               flashing;
		logic               reset_request;
		logic               reboot_request;
		logic               lights_changed;
	} key_status_t;

	typedef struct packed {
		logic [LIGHT_W-1:0] led_drive;
		logic               long_phase;
	} led_status_t;

endpackage

// ----- src/tklc_key_lights.sv -----
module tklc_key_lights #(
	parameter int KEYS_LIVE = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  tklc_pkg::mode_t              mode,
	input  logic [tklc_pkg::LIGHT_W-1:0] key_levels,
	input  logic [1:0]                   channel,
	input  logic                         set_value,
	input  tklc_pkg::thresh_t            thr,
	output tklc_pkg::key_status_t        status
);

	localparam int LW = tklc_pkg::LIGHT_W;
	localparam int CW = tklc_pkg::CNT_W;
	localparam logic [LW-1:0] LIVE_MASK = LW'((1 << KEYS_LIVE) - 1);

	logic [LW-1:0] tog_v;
	logic [LW-1:0] rst_v;
	logic [LW-1:0] rbt_v;
	logic [LW-1:0] fl_v;
	logic [LW-1:0] lights_q;
	logic [LW-1:0] lights_d;
	logic [LW-1:0] set_mask;
	logic          flash_q;
	logic          flash_d;
	logic          scan_en;

	assign scan_en = en && (mode == tklc_pkg::MODE_SCAN);

	for (genvar g = 0; g < LW; g++) begin : g_key
		if (g < KEYS_LIVE) begin : g_live
			logic [CW-1:0] hold_q;
			logic [CW-1:0] hold_d;
			logic          pressed;
			logic          stepped;

			assign pressed = !key_levels[g];
			assign stepped = pressed && (hold_q != {CW{1'b1}});

			always_comb begin
				if (!pressed) begin
					hold_d = '0;
				end else if (stepped) begin
					hold_d = hold_q + CW'(1);
				end else begin
					hold_d = hold_q;
				end
			end

			assign tog_v[g] = stepped && (hold_d == thr.action);
			assign fl_v[g]  = hold_d > thr.reset;
			assign rbt_v[g] = stepped && ({1'b0, hold_d} == ({1'b0, thr.reboot} + (CW+1)'(1)));
			assign rst_v[g] = !pressed && (hold_q >= thr.reset);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hold_q <= '0;
				end else if (scan_en) begin
					hold_q <= hold_d;
				end
			end
		end else begin : g_dead
			// no level bit: never pressed, no light
			assign tog_v[g] = 1'b0;
			assign fl_v[g]  = 1'b0;
			assign rbt_v[g] = 1'b0;
			assign rst_v[g] = 1'b0;
		end
	end

	assign set_mask = (32'(channel) < KEYS_LIVE) ? (LW'(1) << channel) : '0;

	always_comb begin
		lights_d = lights_q;
		flash_d  = flash_q;
		case (mode)
			tklc_pkg::MODE_SCAN: begin
				lights_d = (lights_q ^ tog_v) & LIVE_MASK;
				flash_d  = |fl_v;
			end
			tklc_pkg::MODE_SET: begin
				lights_d = set_value ? (lights_q | set_mask) : (lights_q & ~set_mask);
			end
			default: begin
				lights_d = lights_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lights_q <= '0;
			flash_q  <= 1'b0;
		end else if (en) begin
			lights_q <= lights_d;
			flash_q  <= flash_d;
		end
	end

	assign status.lights         = lights_d;
	assign status.flashing       = flash_d;
	assign status.reset_request  = (mode == tklc_pkg::MODE_SCAN) && (|rst_v);
	assign status.reboot_request = (mode == tklc_pkg::MODE_SCAN) && (|rbt_v);
	assign status.lights_changed = lights_d != lights_q;

endmodule

// ----- src/tklc_led_timer.sv -----
module tklc_led_timer #(
	parameter int KEYS_LIVE    = 3,
	parameter int FLASH_PERIOD = 200
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  logic [tklc_pkg::LIGHT_W-1:0] lights,
	input  logic                         flashing,
	output tklc_pkg::led_status_t        status
);

	localparam int LW       = tklc_pkg::LIGHT_W;
	localparam int FC_W     = $clog2(FLASH_PERIOD);
	localparam int ON_TICKS = FLASH_PERIOD / 2;
	localparam logic [LW-1:0] ALL_ON = LW'((1 << KEYS_LIVE) - 1);

	logic [FC_W-1:0] fc_q;
	logic [FC_W-1:0] fc_d;
	logic [FC_W:0]   fc_inc;
	logic            dim_q;
	logic            dim_d;
	logic [LW-1:0]   led_q;
	logic [LW-1:0]   led_d;

	assign fc_inc = {1'b0, fc_q} + (FC_W+1)'(1);
	assign dim_d  = ~dim_q;

	always_comb begin
		if (!flashing) begin
			fc_d = '0;
		end else if (fc_inc == (FC_W+1)'(FLASH_PERIOD)) begin
			fc_d = '0;
		end else begin
			fc_d = fc_inc[FC_W-1:0];
		end

		// blink while flashing, else alternate full-on and light state
		if (flashing) begin
			led_d = (fc_d < FC_W'(ON_TICKS)) ? ALL_ON : '0;
		end else if (dim_d) begin
			led_d = ALL_ON;
		end else begin
			led_d = lights & ALL_ON;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= '0;
			dim_q <= 1'b0;
			led_q <= '0;
		end else if (tick) begin
			fc_q  <= fc_d;
			dim_q <= dim_d;
			led_q <= led_d;
		end
	end

	assign status.led_drive  = tick ? led_d : led_q;
	assign status.long_phase = tick ? dim_d : dim_q;

endmodule

// ----- src/touch_key_light_controller_unit.sv -----
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  one event word (mode on tuser, key levels, remote set)
// m_*       out        m_tvalid/m_tready  one status word per event word
// cfg_*     in         cfg_wr_en          threshold register write
//
// One word per cycle while the output does not stall; the result appears in the cycle after
// acceptance, held in the single result register behind the state update logic.
// All state except the result word, and all thresholds, are set to their defaults by arst_n.
// s_tready drops only while a result waits and m_tready is low.
module touch_key_light_controller_unit #(
	parameter int NUM_KEYS     = 3,
	parameter int FLASH_PERIOD = 200
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mode[1:0]
	input  logic [1:0]                    s_tuser,
	// key_levels[2:0], channel[4:3], set_value[5], zero[7:6]
	input  logic [tklc_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// lights[2:0], scr_drive[5:3], led_drive[8:6], long_phase[9], flashing[10],
	// reset_request[11], reboot_request[12], lights_changed[13], zero[15:14]
	output logic [tklc_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [tklc_pkg::CNT_W-1:0]    cfg_data
);

	localparam int KEYS_LIVE = (NUM_KEYS < tklc_pkg::LIGHT_W) ? NUM_KEYS : tklc_pkg::LIGHT_W;

	tklc_pkg::thresh_t     thr_q;
	tklc_pkg::mode_t       mode;
	tklc_pkg::key_status_t key_st;
	tklc_pkg::led_status_t led_st;
	logic                  accept;
	logic                  out_valid_q;
	logic [tklc_pkg::OUT_W-1:0] out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.action <= tklc_pkg::ACTION_RST;
			thr_q.reset  <= tklc_pkg::RESET_RST;
			thr_q.reboot <= tklc_pkg::REBOOT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tklc_pkg::REG_ACTION: thr_q.action <= cfg_data;
				tklc_pkg::REG_RESET:  thr_q.reset  <= cfg_data;
				tklc_pkg::REG_REBOOT: thr_q.reboot <= cfg_data;
				default: begin
					thr_q <= thr_q;
				end
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign mode     = tklc_pkg::mode_t'(s_tuser);

	tklc_key_lights #(
		.KEYS_LIVE (KEYS_LIVE)
	) u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.mode       (mode),
		.key_levels (s_tdata[2:0]),
		.channel    (s_tdata[4:3]),
		.set_value  (s_tdata[5]),
		.thr        (thr_q),
		.status     (key_st)
	);

	tklc_led_timer #(
		.KEYS_LIVE    (KEYS_LIVE),
		.FLASH_PERIOD (FLASH_PERIOD)
	) u_led (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (accept && (mode == tklc_pkg::MODE_LED)),
		.lights   (key_st.lights),
		.flashing (key_st.flashing),
		.status   (led_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// result word holds no control state
	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q <= {2'b00, key_st.lights_changed, key_st.reboot_request,
				key_st.reset_request, key_st.flashing, led_st.long_phase,
				led_st.led_drive, ~key_st.lights, key_st.lights};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;

`ifndef SYNTHESIS
	a_scr_inverse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:3] == ~m_tdata[2:0]))
		else $error("scr_drive is not the inverse of lights");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input stalled while the result register can move");

	a_led_keeps_lights: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == tklc_pkg::MODE_LED)) |=> (m_tvalid && !m_tdata[13]))
		else $error("LED tick changed the light states");

	a_pulse_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser != tklc_pkg::MODE_SCAN)) |=> (m_tdata[12:11] == 2'b00))
		else $error("reset or reboot pulse outside a key scan");
`endif

endmodule
